// File: src/emst_pkg.sv
// ----------------------------------------------------------------------------
// emst_pkg
// Shared types and constants for the extent map sector translate unit.
// ----------------------------------------------------------------------------
package emst_pkg;

	// Extent table geometry.
	localparam int MAX_RUNS = 64;
	localparam int RUN_AW   = $clog2(MAX_RUNS);
	localparam int RUN_CW   = $clog2(MAX_RUNS + 1);

	// Field widths fixed by the interface.
	localparam int LCL_W    = 40;
	localparam int PCL_W    = 40;
	localparam int LEN_W    = 32;
	localparam int SEC_W    = 48;
	localparam int CNT_W    = 13;
	localparam int SHIFT_W  = 3;
	localparam int RUNS_W   = 7;
	localparam int CFG_IW   = 1;
	localparam int CFG_DW   = 7;

	// Action codes of an input item.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_XLATE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] CFG_CLUSTER_SHIFT = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_RUNS_IN_USE   = 1'b1;

	// One extent table entry.
	typedef struct packed {
		logic [LCL_W-1:0] lstart;
		logic [PCL_W-1:0] pstart;
		logic [LEN_W-1:0] length;
	} entry_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK_REQ,
		ST_HEAD_GO,
		ST_WALK_HEAD,
		ST_EMIT_HEAD,
		ST_WALK_TAIL,
		ST_EMIT_LAST
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write;
		logic req_go;
		logic head_go;
		logic tail_go;
		logic emit;
		logic emit_last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_done;
		logic walk_split;
		logic out_free;
	} sts_t;

endpackage

// File: src/emst_ctrl.sv
// ----------------------------------------------------------------------------
// emst_ctrl
// Sequencer for loads, the request walk, the split walks and result hand-off.
// ----------------------------------------------------------------------------
module emst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           action,
	output logic           in_ready,
	input  emst_pkg::sts_t sts,
	output emst_pkg::cmd_t cmd
);
	import emst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == ACT_XLATE) begin
						cmd.req_go = 1'b1;
						state_d    = ST_WALK_REQ;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_WALK_REQ: begin
				if (sts.walk_done) begin
					state_d = sts.walk_split ? ST_HEAD_GO : ST_EMIT_LAST;
				end
			end
			ST_HEAD_GO: begin
				cmd.head_go = 1'b1;
				state_d     = ST_WALK_HEAD;
			end
			ST_WALK_HEAD: begin
				if (sts.walk_done) begin
					state_d = ST_EMIT_HEAD;
				end
			end
			ST_EMIT_HEAD: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.tail_go = 1'b1;
					state_d     = ST_WALK_TAIL;
				end
			end
			ST_WALK_TAIL: begin
				if (sts.walk_done) begin
					state_d = ST_EMIT_LAST;
				end
			end
			ST_EMIT_LAST: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: src/emst_dpath.sv
// ----------------------------------------------------------------------------
// emst_dpath
// Extent memory, pipelined extent walk, range compare and result register.
// ----------------------------------------------------------------------------
module emst_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  emst_pkg::cmd_t                    cmd,
	output emst_pkg::sts_t                    sts,
	input  logic [emst_pkg::SHIFT_W-1:0]      sh,
	input  logic [emst_pkg::RUN_CW-1:0]       lim,
	input  logic [5:0]                        entry_index,
	input  logic [emst_pkg::LCL_W-1:0]        run_logical_cluster,
	input  logic [emst_pkg::PCL_W-1:0]        run_physical_cluster,
	input  logic [emst_pkg::LEN_W-1:0]        run_cluster_count,
	input  logic [emst_pkg::SEC_W-1:0]        request_sector,
	input  logic [emst_pkg::CNT_W-1:0]        request_sectors,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [emst_pkg::SEC_W-1:0]        physical_sector,
	output logic [emst_pkg::CNT_W-1:0]        piece_sectors,
	output logic                              map_error,
	output logic                              last
);
	import emst_pkg::*;

	// Extent table.
	entry_t mem_q [MAX_RUNS];
	entry_t rd_s1;

	// Walk control.
	logic              busy_q;
	logic [RUN_CW-1:0] issue_cnt_q;
	logic              v1_q;
	logic              v2_q;
	logic              issue_v;
	logic              walk_go;

	// Second stage: extent bounds in sectors.
	logic [SEC_W-1:0]  es_s2;
	logic [SEC_W:0]    ee_s2;
	logic [SEC_W-1:0]  pb_s2;
	logic              zero_s2;
	logic [SEC_W-1:0]  es_d;
	logic [SEC_W:0]    ee_d;
	logic [SEC_W-1:0]  pb_d;

	// Query range and request.
	logic [SEC_W-1:0]  start_q;
	logic [SEC_W:0]    end_q;
	logic [SEC_W-1:0]  lo_q;
	logic [SEC_W:0]    hi_q;
	logic              primary_q;
	logic [SEC_W-1:0]  split_q;

	// Walk outcome.
	logic              whole;
	logic              split;
	logic              stop;
	logic              drained;
	logic              done;
	logic              res_ok_q;
	logic [SEC_W-1:0]  res_phys_q;

	// Result register.
	logic              out_valid_q;
	logic [SEC_W-1:0]  phys_q;
	logic [CNT_W-1:0]  piece_q;
	logic              err_q;
	logic              last_q;

	assign walk_go = cmd.req_go | cmd.head_go | cmd.tail_go;
	assign issue_v = busy_q && (issue_cnt_q < lim);

	always_ff @(posedge clk) begin
		if (cmd.write && (int'(entry_index) < MAX_RUNS)) begin
			mem_q[entry_index[RUN_AW-1:0]] <= '{lstart: run_logical_cluster,
				pstart: run_physical_cluster, length: run_cluster_count};
		end
		rd_s1 <= mem_q[issue_cnt_q[RUN_AW-1:0]];
	end

	always_comb begin
		es_d = {{(SEC_W-LCL_W){1'b0}}, rd_s1.lstart} << sh;
		ee_d = {1'b0, es_d} + ({{(SEC_W+1-LEN_W){1'b0}}, rd_s1.length} << sh);
		pb_d = ({{(SEC_W-PCL_W){1'b0}}, rd_s1.pstart} << sh) - es_d;
	end

	always_ff @(posedge clk) begin
		es_s2   <= es_d;
		ee_s2   <= ee_d;
		pb_s2   <= pb_d;
		zero_s2 <= (rd_s1.length == '0);
	end

	always_comb begin
		whole   = v2_q && !zero_s2 && (lo_q >= es_s2) && (hi_q <= ee_s2);
		split   = v2_q && !zero_s2 && primary_q && (lo_q < es_s2)
			&& (hi_q > {1'b0, es_s2}) && (hi_q <= ee_s2);
		stop    = busy_q && (whole || split || (v2_q && zero_s2));
		drained = busy_q && !issue_v && !v1_q && !v2_q;
		done    = stop || drained;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			issue_cnt_q <= '0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
		end else if (walk_go) begin
			busy_q      <= 1'b1;
			issue_cnt_q <= '0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
		end else begin
			if (done) begin
				busy_q <= 1'b0;
			end
			if (issue_v && !stop) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
			v1_q <= issue_v && !stop;
			v2_q <= v1_q && !stop;
		end
	end

	// Range under test for the current walk.
	always_ff @(posedge clk) begin
		if (cmd.req_go) begin
			start_q   <= request_sector;
			end_q     <= {1'b0, request_sector} + (SEC_W+1)'(request_sectors);
			lo_q      <= request_sector;
			hi_q      <= {1'b0, request_sector} + (SEC_W+1)'(request_sectors);
			primary_q <= 1'b1;
		end else if (cmd.head_go) begin
			lo_q      <= start_q;
			hi_q      <= {1'b0, split_q};
			primary_q <= 1'b0;
		end else if (cmd.tail_go) begin
			lo_q      <= split_q;
			hi_q      <= end_q;
			primary_q <= 1'b0;
		end
		if (done) begin
			res_ok_q   <= whole;
			res_phys_q <= lo_q + pb_s2;
		end
		if (split) begin
			split_q <= es_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The piece length is the width of the range just walked.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			phys_q  <= res_ok_q ? res_phys_q : '0;
			piece_q <= CNT_W'(hi_q - {1'b0, lo_q});
			err_q   <= !res_ok_q;
			last_q  <= cmd.emit_last;
		end
	end

	assign sts.walk_done  = done;
	assign sts.walk_split = split;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign physical_sector = phys_q;
	assign piece_sectors   = piece_q;
	assign map_error       = err_q;
	assign last            = last_q;

endmodule

// File: src/extent_map_sector_translate_unit.sv
// ----------------------------------------------------------------------------
// extent_map_sector_translate_unit
// Translates logical sector requests to physical sectors via an extent table.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Moves
//   in       in_valid / in_ready   one item: an extent load or a translate
//   out      out_valid / out_ready one result item per request piece
//   cfg      cfg_we                cluster_shift or runs_in_use write
//
// A load item produces no result. A translate item walks the extent memory one
// slot per cycle through its single read port, over at most min(runs_in_use, 64)
// slots; a split request then runs a setup state and two more walks, one for
// the head piece and one for the tail piece.
// Reset clears the controller, the walk pipeline, the configuration registers
// and the result valid flag; the extent memory is not cleared. A stalled
// output holds its result while the next item is accepted and walked.
//
module extent_map_sector_translate_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [5:0]                     entry_index,
	input  logic [emst_pkg::LCL_W-1:0]     run_logical_cluster,
	input  logic [emst_pkg::PCL_W-1:0]     run_physical_cluster,
	input  logic [emst_pkg::LEN_W-1:0]     run_cluster_count,
	input  logic [emst_pkg::SEC_W-1:0]     request_sector,
	input  logic [emst_pkg::CNT_W-1:0]     request_sectors,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [emst_pkg::SEC_W-1:0]     physical_sector,
	output logic [emst_pkg::CNT_W-1:0]     piece_sectors,
	output logic                           map_error,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [emst_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [emst_pkg::CFG_DW-1:0]    cfg_data
);
	import emst_pkg::*;

	cmd_t               cmd;
	sts_t               sts;
	logic [SHIFT_W-1:0] cluster_shift_q;
	logic [RUNS_W-1:0]  runs_in_use_q;
	logic [RUN_CW-1:0]  lim;

	// Configuration registers. The user must write them only while the unit is idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_shift_q <= '0;
			runs_in_use_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLUSTER_SHIFT: cluster_shift_q <= cfg_data[SHIFT_W-1:0];
				CFG_RUNS_IN_USE:   runs_in_use_q   <= cfg_data[RUNS_W-1:0];
				default: ;
			endcase
		end
	end

	// The walk never goes past the end of the table, whatever is configured.
	always_comb begin
		if (int'(runs_in_use_q) > MAX_RUNS) begin
			lim = RUN_CW'(MAX_RUNS);
		end else begin
			lim = RUN_CW'(runs_in_use_q);
		end
	end

	emst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	emst_dpath u_dpath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.sh                   (cluster_shift_q),
		.lim                  (lim),
		.entry_index          (entry_index),
		.run_logical_cluster  (run_logical_cluster),
		.run_physical_cluster (run_physical_cluster),
		.run_cluster_count    (run_cluster_count),
		.request_sector       (request_sector),
		.request_sectors      (request_sectors),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.physical_sector      (physical_sector),
		.piece_sectors        (piece_sectors),
		.map_error            (map_error),
		.last                 (last)
	);

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the extent map sector translate unit. Loads extent
// tables, drives translate requests around extent edges and holes under random
// flow control on both channels, and checks every result piece in order.
// ----------------------------------------------------------------------------
module tb;
	import emst_pkg::*;

	// Upper bound on the run; the slowest legal run is far below this.
	localparam int unsigned CYCLE_LIMIT = 3000000;
	// A translate with a split walks three times over up to 64 slots, so give
	// the block this long to finish any load or walk still in flight.
	localparam int SETTLE_CYCLES = 300;
	// Receiver hold-off used once to back the block up into its input.
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 10;
	localparam int PHASE_REQUESTS = 40;

	// One input item as seen on the input channel.
	typedef struct {
		logic             action;
		logic [5:0]       slot;
		logic [LCL_W-1:0] lcl;
		logic [PCL_W-1:0] pcl;
		logic [LEN_W-1:0] len;
		logic [SEC_W-1:0] sec;
		logic [CNT_W-1:0] cnt;
	} map_item_t;

	// One result item: a mapped (or unmapped) piece of a request.
	typedef struct {
		logic [SEC_W-1:0] phys;
		logic [CNT_W-1:0] cnt;
		logic             err;
		logic             last;
	} piece_t;

	// Keeps a private copy of the extent table and the two registers, works
	// out the pieces each accepted request must produce, and checks the
	// results against them in arrival order.
	class extent_map_board;
		logic [LCL_W-1:0]   lstart_tab [MAX_RUNS];
		logic [PCL_W-1:0]   pstart_tab [MAX_RUNS];
		logic [LEN_W-1:0]   len_tab [MAX_RUNS];
		logic [SHIFT_W-1:0] shift;
		logic [RUNS_W-1:0]  runs;
		piece_t             pending_pieces [$];
		int                 mismatches;

		function new();
			shift = '0;
			runs = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] index, logic [CFG_DW-1:0] data);
			if (index == CFG_CLUSTER_SHIFT) begin
				shift = data[SHIFT_W-1:0];
			end else if (index == CFG_RUNS_IN_USE) begin
				runs = data[RUNS_W-1:0];
			end
		endfunction

		function int walk_bound();
			return (runs < MAX_RUNS) ? int'(runs) : MAX_RUNS;
		endfunction

		function piece_t make_piece(bit ok, logic [63:0] phys, logic [63:0] n, bit fin);
			piece_t p;
			p.phys = ok ? phys[SEC_W-1:0] : '0;
			p.cnt = n[CNT_W-1:0];
			p.err = !ok;
			p.last = fin;
			return p;
		endfunction

		// First extent that holds all of [lo, hi), as used for each split piece.
		function bit find_cover(logic [63:0] lo, logic [63:0] hi, output logic [63:0] phys);
			logic [63:0] es, ee;
			phys = '0;
			for (int i = 0; i < walk_bound(); i++) begin
				if (len_tab[i] == '0) break;
				es = 64'(lstart_tab[i]) << shift;
				ee = es + (64'(len_tab[i]) << shift);
				if (lo >= es && hi <= ee) begin
					phys = lo - es + (64'(pstart_tab[i]) << shift);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void take_item(map_item_t it);
			logic [63:0] start, stop, es, ee, p;
			bit ok;
			if (it.action == ACT_LOAD) begin
				lstart_tab[it.slot] = it.lcl;
				pstart_tab[it.slot] = it.pcl;
				len_tab[it.slot] = it.len;
				return;
			end
			start = 64'(it.sec);
			stop = start + 64'(it.cnt);
			for (int i = 0; i < walk_bound(); i++) begin
				if (len_tab[i] == '0) break;
				es = 64'(lstart_tab[i]) << shift;
				ee = es + (64'(len_tab[i]) << shift);
				if (start >= es && stop <= ee) begin
					p = start - es + (64'(pstart_tab[i]) << shift);
					pending_pieces.push_back(make_piece(1'b1, p, 64'(it.cnt), 1'b1));
					return;
				end
				// Request starts before this extent and ends inside it: cut at
				// the extent start and map both halves with fresh walks.
				if (start < es && stop > es && stop <= ee) begin
					ok = find_cover(start, es, p);
					pending_pieces.push_back(make_piece(ok, p, es - start, 1'b0));
					ok = find_cover(es, stop, p);
					pending_pieces.push_back(make_piece(ok, p, stop - es, 1'b1));
					return;
				end
			end
			pending_pieces.push_back(make_piece(1'b0, '0, 64'(it.cnt), 1'b1));
		endfunction

		function string show(piece_t p);
			return $sformatf("phys=%h cnt=%0d err=%b last=%b", p.phys, p.cnt, p.err, p.last);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) $display("%s", msg);
		endfunction

		function void take_result(piece_t got);
			piece_t want;
			if (pending_pieces.size() == 0) begin
				flag({"unexpected result: ", show(got)});
				return;
			end
			want = pending_pieces.pop_front();
			if (got.phys !== want.phys || got.cnt !== want.cnt ||
					got.err !== want.err || got.last !== want.last) begin
				flag({"mismatch: expected ", show(want), ", got ", show(got)});
			end
		endfunction

		function void close();
			while (pending_pieces.size() != 0) begin
				flag({"missing result: ", show(pending_pieces.pop_front())});
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             action;
	logic [5:0]       entry_index;
	logic [LCL_W-1:0] run_logical_cluster;
	logic [PCL_W-1:0] run_physical_cluster;
	logic [LEN_W-1:0] run_cluster_count;
	logic [SEC_W-1:0] request_sector;
	logic [CNT_W-1:0] request_sectors;
	logic             out_valid;
	logic             out_ready;
	logic [SEC_W-1:0] physical_sector;
	logic [CNT_W-1:0] piece_sectors;
	logic             map_error;
	logic             last;
	logic             cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	extent_map_board board;
	int unsigned cycle_count = 0;
	// When set, neither side inserts gaps.
	bit quiet;
	// Set by the stimulus to make the receiver hold off for this many cycles.
	int out_hold;

	extent_map_sector_translate_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.entry_index(entry_index),
		.run_logical_cluster(run_logical_cluster),
		.run_physical_cluster(run_physical_cluster),
		.run_cluster_count(run_cluster_count),
		.request_sector(request_sector),
		.request_sectors(request_sectors),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.physical_sector(physical_sector),
		.piece_sectors(piece_sectors),
		.map_error(map_error),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Hard stop in case the block hangs or loses a handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Everything is observed at the rising edge, where the inputs driven at
	// the falling edge are stable and the outputs still hold their pre-edge
	// values. Register writes, accepted items and accepted results all go to
	// the board from this one place so their order is fixed.
	always @(posedge clk) begin : watch
		map_item_t seen;
		piece_t got;
		if (arst_n) begin
			if (cfg_we) board.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				seen.action = action;
				seen.slot = entry_index;
				seen.lcl = run_logical_cluster;
				seen.pcl = run_physical_cluster;
				seen.len = run_cluster_count;
				seen.sec = request_sector;
				seen.cnt = request_sectors;
				board.take_item(seen);
			end
			if (out_valid && out_ready) begin
				got.phys = physical_sector;
				got.cnt = piece_sectors;
				got.err = map_error;
				got.last = last;
				board.take_result(got);
			end
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(12, 80);
	endfunction

	// Receiver: alternates ready stretches with random gaps, and honors a
	// one-off long hold-off requested by the stimulus. Each pass moves at
	// least one falling edge before ready is driven again.
	initial begin : receiver
		int gap;
		int hold;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (out_hold > 0) begin
				hold = out_hold;
				out_hold = 0;
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat (quiet ? 8 : $urandom_range(0, 6)) @(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is
	// taken, leaving valid high so a back-to-back item needs no second write.
	task automatic send(map_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action <= it.action;
		entry_index <= it.slot;
		run_logical_cluster <= it.lcl;
		run_physical_cluster <= it.pcl;
		run_cluster_count <= it.len;
		request_sector <= it.sec;
		request_sectors <= it.cnt;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Fields that an item does not use still carry random values.
	function automatic map_item_t random_item();
		map_item_t it;
		it.action = 1'($urandom);
		it.slot = 6'($urandom);
		it.lcl = {8'($urandom), 32'($urandom)};
		it.pcl = {8'($urandom), 32'($urandom)};
		it.len = $urandom;
		it.sec = {16'($urandom), 32'($urandom)};
		it.cnt = 13'($urandom_range(1, 4096));
		return it;
	endfunction

	task automatic send_load(logic [5:0] slot, logic [LCL_W-1:0] lcl, logic [PCL_W-1:0] pcl,
			logic [LEN_W-1:0] len);
		map_item_t it;
		it = random_item();
		it.action = ACT_LOAD;
		it.slot = slot;
		it.lcl = lcl;
		it.pcl = pcl;
		it.len = len;
		send(it);
	endtask

	task automatic send_xlate(logic [SEC_W-1:0] sec, logic [CNT_W-1:0] cnt);
		map_item_t it;
		it = random_item();
		it.action = ACT_XLATE;
		it.sec = sec;
		it.cnt = cnt;
		send(it);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] index, logic [CFG_DW-1:0] data);
		cfg_index <= index;
		cfg_data <= data;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Lowers valid, waits for every expected piece, then lets any load or
	// walk still inside the block drain out before registers change.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_pieces.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly short requests so pieces fit inside small extents, some large,
	// a rare empty one.
	function automatic logic [CNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 13'($urandom_range(1, 4096));
		if (r < 13) return 13'd4096;
		if (r < 15) return '0;
		return 13'($urandom_range(1, 48));
	endfunction

	// Lays out k extents in logical order with the odd hole, short lengths
	// and now and then a huge one, then with term and room a zero-length end slot.
	task automatic build_table(int k, bit term);
		logic [LCL_W-1:0] cursor;
		logic [LEN_W-1:0] n;
		cursor = {8'($urandom), 32'($urandom)};
		for (int i = 0; i < k; i++) begin
			if ($urandom_range(0, 3) == 0) cursor = cursor + $urandom_range(1, 3);
			n = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 6);
			send_load(6'(i), cursor, {8'($urandom), 32'($urandom)}, n);
			cursor = cursor + n;
		end
		if (term && k < MAX_RUNS) begin
			send_load(6'(k), {8'($urandom), 32'($urandom)}, {8'($urandom), 32'($urandom)}, '0);
		end
	endtask

	// Aims most requests at a loaded extent: inside it, straddling its start
	// so the request splits, or running off its end. The rest are noise.
	task automatic send_request(int k);
		map_item_t it;
		logic [63:0] es, span;
		int r, i, back;
		it = random_item();
		it.action = ACT_XLATE;
		it.cnt = pick_count();
		r = $urandom_range(0, 99);
		if (k > 0 && r >= 12) begin
			i = $urandom_range(0, k - 1);
			es = 64'(board.lstart_tab[i]) << board.shift;
			span = 64'(board.len_tab[i]) << board.shift;
			if (r < 50) begin
				it.sec = SEC_W'(es + ((span != 0) ? 64'($urandom_range(0, 199)) % span
					: 64'd0));
			end else if (r < 85) begin
				back = $urandom_range(1, 40);
				it.sec = SEC_W'(es - 64'(back));
				it.cnt = 13'(back + $urandom_range(1, 40));
			end else begin
				it.sec = SEC_W'(es + span - 64'($urandom_range(1, 8)));
			end
		end
		send(it);
	endtask

	// A stray load to any slot, often short or zero length, which reshapes
	// the table in the middle of a phase.
	task automatic send_random_load();
		map_item_t it;
		it = random_item();
		it.action = ACT_LOAD;
		if ($urandom_range(0, 1) == 1) it.len = $urandom_range(0, 6);
		send(it);
	endtask

	// One phase: register settings, a fresh table, then a stream of requests
	// with a few loads mixed in. Some phases pin the register extremes, one
	// backs up the output, one runs with no gaps at all.
	task automatic run_phase(int p);
		int sh, runs, k;
		bit term;
		sh = $urandom_range(0, 7);
		k = $urandom_range(1, 12);
		term = 1'b1;
		case (p)
			0: sh = 0;
			1: sh = 7;
			3, 4: begin
				k = MAX_RUNS;
				term = 1'b0;
			end
			default: ;
		endcase
		runs = ($urandom_range(0, 3) == 0 && k > 1) ? k - 1 : k + $urandom_range(0, 2);
		if (p == 2) runs = 0;
		if (p == 3) runs = MAX_RUNS;
		if (p == 4) runs = 127;
		write_reg(CFG_CLUSTER_SHIFT, CFG_DW'(sh));
		write_reg(CFG_RUNS_IN_USE, CFG_DW'(runs));
		build_table(k, term);
		quiet = (p == 6);
		if (p == 5) out_hold = HOLD_CYCLES;
		repeat (PHASE_REQUESTS) begin
			if ($urandom_range(0, 99) < 8) send_random_load();
			else send_request(k);
		end
		settle();
		quiet = 1'b0;
	endtask

	initial begin : stimulus
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_LOAD;
		entry_index = '0;
		run_logical_cluster = '0;
		run_physical_cluster = '0;
		run_cluster_count = '0;
		request_sector = '0;
		request_sectors = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_CLUSTER_SHIFT;
		cfg_data = '0;
		quiet = 1'b0;
		out_hold = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The extent memory powers up unknown; write every slot once so no
		// walk can ever touch an unwritten entry.
		for (int i = 0; i < MAX_RUNS; i++) begin
			send_load(6'(i), {8'($urandom), 32'($urandom)}, {8'($urandom), 32'($urandom)}, '0);
		end
		settle();

		// Small hand-built table: [100,104) -> 0, [104,108) -> 2000, a hole,
		// [120,122) -> 5000, then a zero-length slot.
		write_reg(CFG_CLUSTER_SHIFT, '0);
		write_reg(CFG_RUNS_IN_USE, 8);
		send_load(0, 100, 0, 4);
		send_load(1, 104, 2000, 4);
		send_load(2, 120, 5000, 2);
		send_load(3, 7, 7, 0);
		send_xlate(100, 1);      // maps onto physical sector zero
		send_xlate(104, 4);      // exactly fills an extent
		send_xlate(102, 4);      // split across two adjacent extents
		send_xlate(98, 2);       // ends right at an extent start, so no split
		send_xlate(98, 4);       // split with an unmapped head
		send_xlate(106, 16);     // head of the split spans the hole
		send_xlate(101, 0);      // empty request inside an extent
		send_xlate(110, 0);      // empty request in the hole
		send_xlate(0, 4096);     // nothing covers it
		send_xlate('1, 4096);    // top of the sector range
		settle();

		// Largest cluster size with an extent whose fields are all ones.
		write_reg(CFG_CLUSTER_SHIFT, 7);
		write_reg(CFG_RUNS_IN_USE, MAX_RUNS);
		send_load(0, '1, '1, '1);
		send_load(1, 0, 0, 0);
		send_xlate(48'h7FFF_FFFF_FF80, 1);
		send_xlate(48'h7FFF_FFFF_FF80 + 4000, 4096);
		send_xlate(48'h7FFF_FFFF_FF7F, 2);
		settle();

		for (int p = 0; p < PHASES; p++) run_phase(p);

		board.close();
		if (board.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
